// ----- src/ksc_pkg.sv -----
// Shared types, codes and character helpers for the keyword substitution cipher.
`default_nettype none

package ksc_pkg;

  localparam int unsigned Letters = 26;
  localparam int unsigned LetterW = $clog2(Letters);
  localparam int unsigned ByteW   = 8;

  localparam logic [ByteW-1:0] CharUpperA = 8'h41;
  localparam logic [ByteW-1:0] CharUpperZ = 8'h5A;
  localparam logic [ByteW-1:0] CharLowerA = 8'h61;
  localparam logic [ByteW-1:0] CharLowerZ = 8'h7A;

  typedef logic [LetterW-1:0] letter_t;

  typedef enum logic [1:0] {
    OP_KEYWORD   = 2'd0,
    OP_FINISH    = 2'd1,
    OP_TRANSFORM = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FILL = 1'b1
  } ksc_state_e;

  typedef struct packed {
    logic    is_letter;
    logic    is_lower;
    letter_t idx;
  } char_class_t;

  function automatic char_class_t classify(input logic [ByteW-1:0] b);
    char_class_t     c;
    logic [ByteW-1:0] diff;
    c    = '0;
    diff = '0;
    if (b >= CharUpperA && b <= CharUpperZ) begin
      diff        = b - CharUpperA;
      c.is_letter = 1'b1;
      c.idx       = diff[LetterW-1:0];
    end else if (b >= CharLowerA && b <= CharLowerZ) begin
      diff        = b - CharLowerA;
      c.is_letter = 1'b1;
      c.is_lower  = 1'b1;
      c.idx       = diff[LetterW-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/keyword_substitution_cipher_top.sv -----
// Keyword substitution cipher: key build, key/inverse memories and transform pipeline.
// Usage:
//   Input words carry op_i and byte_in_i. op KEYWORD appends the uppercased
//   letter to the key if not yet used (a keyword after a finished key starts a
//   new key); op FINISH appends the unused letters Z down to A; op TRANSFORM
//   enciphers a byte, or deciphers it when decrypt mode is set. Code 3 is
//   accepted and dropped. Only TRANSFORM gives an output word.
//   Key and inverse tables live in two 26x5 synchronous RAMs; the inverse
//   entry is written together with each key entry.
//   Throughput: keyword and transform words are taken one per cycle while in_stall_o
//   is low. A finish word is followed by a walk over the letters Z down to A
//   (at most one RAM write per cycle) during which in_stall_o is high.
//   Output path: a transform word passes the RAM read register, then the
//   output register.
//   Receiver stall: the output register holds its word; one more transform
//   waits in the read stage, then in_stall_o rises.
//   Reset clears the key state, decrypt mode and all valids; the tables are
//   not cleared; their read data is only used once a key is finished.
//   Config: cfg_decrypt_mode_i is taken whenever cfg_valid_i is high
//   (cfg_ready_o is always high); write it only while the block is idle.
`default_nettype none

module keyword_substitution_cipher_top
  import ksc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_decrypt_mode_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [ByteW-1:0]   byte_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ByteW-1:0]        byte_out_o,
  output logic                    key_ready_o
);

  localparam logic [LetterW:0] FillFull = (LetterW+1)'(Letters);
  localparam letter_t          LastLetter = LetterW'(Letters - 1);

  ksc_state_e state_q, state_d;

  letter_t          cnt_q, cnt_d;
  logic [Letters-1:0] used_q, used_d;
  logic [LetterW:0] fill_q, fill_d;
  logic             done_q, done_d;
  logic             dec_q;

  logic walk_active;
  logic in_acc;
  logic s1_adv;

  char_class_t cc;
  op_e         op;

  logic    wr_en;
  letter_t wr_pos;
  letter_t wr_letter;
  logic    rd_en;

  letter_t key_mem [Letters];
  letter_t inv_mem [Letters];
  letter_t key_rd_q;
  letter_t inv_rd_q;

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_letter_q;
  logic             s1_lower_q;
  logic             s1_done_q;
  logic             s1_inv_q;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_ready_q;
  letter_t          mapped;
  logic [ByteW-1:0] out_byte_d;

  assign cc     = classify(byte_in_i);
  assign op     = op_e'(op_i);
  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign rd_en  = in_acc && (op == OP_TRANSFORM);

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_FINISH) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (cnt_q == '0) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    walk_active = 1'b0;
    in_stall_o  = s1_valid_q && !s1_adv;
    unique case (state_q)
      ST_IDLE: ;
      ST_FILL: begin
        walk_active = 1'b1;
        in_stall_o  = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // key state update and RAM write port
  always_comb begin
    cnt_d     = cnt_q;
    used_d    = used_q;
    fill_d    = fill_q;
    done_d    = done_q;
    wr_en     = 1'b0;
    wr_pos    = fill_q[LetterW-1:0];
    wr_letter = cnt_q;
    if (walk_active) begin
      if (!used_q[cnt_q]) begin
        wr_en             = 1'b1;
        used_d[cnt_q]     = 1'b1;
        fill_d            = fill_q + 1'b1;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) done_d = 1'b1;
    end else if (in_acc) begin
      case (op)
        OP_KEYWORD: begin
          // a keyword word after a finished key starts over
          if (done_q) begin
            used_d = '0;
            fill_d = '0;
          end
          done_d = 1'b0;
          if (cc.is_letter && !used_d[cc.idx]) begin
            wr_en           = 1'b1;
            wr_pos          = fill_d[LetterW-1:0];
            wr_letter       = cc.idx;
            used_d[cc.idx]  = 1'b1;
            fill_d          = fill_d + 1'b1;
          end
        end
        OP_FINISH: cnt_d = LastLetter;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      fill_q  <= '0;
      done_q  <= 1'b0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (cfg_valid_i) dec_q <= cfg_decrypt_mode_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // key and inverse tables; inverse entry written with its key entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_pos]    <= wr_letter;
      inv_mem[wr_letter] <= wr_pos;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[cc.idx];
      inv_rd_q <= inv_mem[cc.idx];
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rd_en) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_byte_q   <= byte_in_i;
      s1_letter_q <= cc.is_letter;
      s1_lower_q  <= cc.is_lower;
      s1_done_q   <= done_q;
      s1_inv_q    <= dec_q;
    end
  end

  // output stage
  assign mapped = s1_inv_q ? inv_rd_q : key_rd_q;

  always_comb begin
    out_byte_d = s1_byte_q;
    if (s1_done_q && s1_letter_q) begin
      out_byte_d = (s1_lower_q ? CharLowerA : CharUpperA) + {{(ByteW-LetterW){1'b0}}, mapped};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q  <= out_byte_d;
      out_ready_q <= s1_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = out_byte_q;
  assign key_ready_o = out_ready_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill position past table end");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (fill_q == FillFull && used_q == '1))
    else $error("finished key without all letters placed");

  a_walk_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && cnt_q == '0) |=> (done_q && state_q == ST_IDLE))
    else $error("walk did not finish the key");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !wr_en)
    else $error("table write and read in the same cycle");

  // read data only matters once a key is finished and every entry is written
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_done_q && !s1_adv) |=>
      (s1_valid_q && $stable(key_rd_q) && $stable(inv_rd_q)))
    else $error("pending read data lost");

endmodule

`default_nettype wire
